// ----- src/ipcs_pkg.sv -----
`default_nettype none

package ipcs_pkg;

   // Protocol number of TCP, folded into the pseudo header sum.
   localparam logic [15:0] ProtoTcp = 16'd6;

   // Default depth of the queue between the front and the back end.
   localparam int QueueDepth = 4;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_SHORT_HEADER = 2'd1,
      STATUS_SHORT_TOTAL  = 2'd2
   } status_type;

   // One classified packet word as it travels from the front to the back end.
   typedef struct packed {
      logic [15:0] word;             // raw word for IP header and pseudo header sums
      logic [15:0] seg_word;         // word with bytes past the total length zeroed
      logic        first;            // first word of a packet, sums restart
      logic        ip_add;           // word enters the IP header sum
      logic        pseudo_add;       // word is a source or destination address word
      logic        seg_add;          // word enters the TCP segment sum
      logic        emit;             // last word, a result follows
      logic [15:0] total_length;
      logic [3:0]  header_words;
      logic [3:0]  tcp_header_words;
   } item_type;

   // One's-complement addition with end-around carry.
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] t;
      t = {1'b0, a} + {1'b0, b};
      return t[15:0] + {15'b0, t[16]};
   endfunction

endpackage

`default_nettype wire

// ----- src/ipcs_front.sv -----
`default_nettype none

module ipcs_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [15:0]        req_packet_word,
   input  wire logic               req_start_flag,
   input  wire logic               q_full,
   output logic                    q_push,
   output ipcs_pkg::item_type      q_item
);

   logic [14:0] word_count_ff, word_count_in;
   logic [3:0]  header_words_ff, header_words_in;
   logic [15:0] total_length_ff, total_length_in;
   logic [3:0]  tcp_header_words_ff, tcp_header_words_in;
   logic        active_ff, active_in;

   logic        accept;
   logic [14:0] idx;
   logic [3:0]  hw_eff;
   logic [15:0] tl_eff;
   logic [3:0]  thw_eff;
   logic [14:0] hdr_end;
   logic        seg_take;
   logic [14:0] seg_idx;
   logic [15:0] seg_word;
   logic [15:0] next_idx;
   logic        emit;

   assign req_stall = q_full;

   // Classify the beat: word index, which sums it enters and whether it closes the packet.
   always_comb begin
      accept  = req_valid && !q_full;
      idx     = req_start_flag ? 15'd0 : word_count_ff;
      hw_eff  = req_start_flag ? 4'd0 : header_words_ff;
      tl_eff  = req_start_flag ? 16'd0 : total_length_ff;
      thw_eff = req_start_flag ? 4'd0 : tcp_header_words_ff;
      if (idx == 15'd0) begin
         hw_eff = req_packet_word[11:8];
      end
      if (idx == 15'd1) begin
         tl_eff = req_packet_word;
      end
      hdr_end  = {10'b0, hw_eff, 1'b0};
      seg_take = idx >= hdr_end;
      seg_idx  = idx - hdr_end;
      if (seg_take && seg_idx == 15'd6) begin
         thw_eff = req_packet_word[15:12];
      end

      // Bytes at or past the total length never enter the segment sum.
      seg_word = req_packet_word;
      if (idx != 15'd0) begin
         if ({idx, 1'b0} >= tl_eff) begin
            seg_word = 16'h0000;
         end else if ({idx, 1'b1} >= tl_eff) begin
            seg_word = req_packet_word & 16'hFF00;
         end
      end

      next_idx = {1'b0, idx} + 16'd1;
      emit     = (idx != 15'd0) && ({next_idx, 1'b0} >= {1'b0, tl_eff});

      q_push = accept && (req_start_flag || active_ff);

      q_item.word             = req_packet_word;
      q_item.seg_word         = seg_word;
      q_item.first            = req_start_flag;
      q_item.ip_add           = (idx < hdr_end) && (idx != 15'd5);
      q_item.pseudo_add       = (idx >= 15'd6) && (idx <= 15'd9);
      q_item.seg_add          = seg_take && (seg_idx != 15'd8);
      q_item.emit             = emit;
      q_item.total_length     = tl_eff;
      q_item.header_words     = hw_eff;
      q_item.tcp_header_words = thw_eff;

      word_count_in       = word_count_ff;
      header_words_in     = header_words_ff;
      total_length_in     = total_length_ff;
      tcp_header_words_in = tcp_header_words_ff;
      active_in           = active_ff;
      if (q_push) begin
         word_count_in       = next_idx[14:0];
         header_words_in     = hw_eff;
         total_length_in     = tl_eff;
         tcp_header_words_in = thw_eff;
         active_in           = !emit;
      end
   end

   // Packet tracking state.
   always_ff @(posedge clock) begin
      if (reset) begin
         word_count_ff       <= '0;
         header_words_ff     <= '0;
         total_length_ff     <= '0;
         tcp_header_words_ff <= '0;
         active_ff           <= 1'b0;
      end else begin
         word_count_ff       <= word_count_in;
         header_words_ff     <= header_words_in;
         total_length_ff     <= total_length_in;
         tcp_header_words_ff <= tcp_header_words_in;
         active_ff           <= active_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/ipcs_queue.sv -----
`default_nettype none

module ipcs_queue #(
   parameter int Depth = ipcs_pkg::QueueDepth
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire ipcs_pkg::item_type  push_item,
   output logic                     full,
   input  wire logic                pop,
   output logic                     pop_valid,
   output ipcs_pkg::item_type       pop_item
);

   // Depth must be a power of two so the pointers wrap on their own; the queue does not check this.
   localparam int PtrW   = $clog2(Depth);
   localparam int CountW = $clog2(Depth + 1);

   ipcs_pkg::item_type entry_ff [Depth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0]  count_ff, count_in;

   assign full      = (count_ff == CountW'(Depth));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

// ----- src/ipcs_back.sv -----
`default_nettype none

module ipcs_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire ipcs_pkg::item_type  q_item,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [15:0]              rsp_ip_checksum,
   output logic [15:0]              rsp_tcp_checksum,
   output logic [15:0]              rsp_tcp_length,
   output logic [6:0]               rsp_payload_offset,
   output logic [15:0]              rsp_payload_length,
   output logic [1:0]               rsp_status
);

   // A closed packet waiting for its result fields to be formed.
   typedef struct packed {
      logic [15:0] ip_sum;
      logic [15:0] tcp_sum;
      logic [15:0] total_length;
      logic [3:0]  header_words;
      logic [3:0]  tcp_header_words;
   } done_type;

   logic [15:0] ip_sum_ff, ip_sum_in;
   logic [15:0] tcp_sum_ff, tcp_sum_in;
   done_type    done_ff, done_in;
   logic        done_valid_ff, done_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] ip_ck_ff, ip_ck_in;
   logic [15:0] tcp_ck_ff, tcp_ck_in;
   logic [15:0] tcp_len_ff, tcp_len_in;
   logic [6:0]  offset_ff, offset_in;
   logic [15:0] pay_len_ff, pay_len_in;
   ipcs_pkg::status_type status_ff, status_in;

   logic        rsp_free;
   logic        done_move;
   logic        done_free;
   logic [15:0] ip_base, tcp_base, tcp_mid;
   logic [5:0]  hdr_bytes;
   logic [4:0]  hdr_sum;

   // Handshake between the stages.
   always_comb begin
      rsp_free  = !rsp_valid_ff || !rsp_stall;
      done_move = done_valid_ff && rsp_free;
      done_free = !done_valid_ff || rsp_free;
      q_pop     = q_valid && (!q_item.emit || done_free);
   end

   // Accumulate one beat into both running sums, pseudo header before segment.
   always_comb begin
      ip_base  = q_item.first ? 16'h0000 : ip_sum_ff;
      tcp_base = q_item.first ? 16'h0000 : tcp_sum_ff;
      ip_sum_in = q_item.ip_add ? ipcs_pkg::oc_add(ip_base, q_item.word) : ip_base;
      tcp_mid   = q_item.pseudo_add ? ipcs_pkg::oc_add(tcp_base, q_item.word) : tcp_base;
      tcp_sum_in = q_item.seg_add ? ipcs_pkg::oc_add(tcp_mid, q_item.seg_word) : tcp_mid;

      done_in.ip_sum           = ip_sum_in;
      done_in.tcp_sum          = tcp_sum_in;
      done_in.total_length     = q_item.total_length;
      done_in.header_words     = q_item.header_words;
      done_in.tcp_header_words = q_item.tcp_header_words;

      if (q_pop && q_item.emit) begin
         done_valid_in = 1'b1;
      end else if (done_move) begin
         done_valid_in = 1'b0;
      end else begin
         done_valid_in = done_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ip_sum_ff     <= '0;
         tcp_sum_ff    <= '0;
         done_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            ip_sum_ff  <= ip_sum_in;
            tcp_sum_ff <= tcp_sum_in;
         end
         done_valid_ff <= done_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_item.emit) begin
         done_ff <= done_in;
      end
   end

   // Lengths, status and the final checksums of a closed packet.
   always_comb begin
      hdr_bytes = {done_ff.header_words, 2'b00};
      hdr_sum   = {1'b0, done_ff.header_words} + {1'b0, done_ff.tcp_header_words};
      offset_in = {hdr_sum, 2'b00};

      if (done_ff.total_length >= {10'b0, hdr_bytes}) begin
         tcp_len_in = done_ff.total_length - {10'b0, hdr_bytes};
      end else begin
         tcp_len_in = 16'd0;
      end

      if (done_ff.total_length > {9'b0, offset_in}) begin
         pay_len_in = done_ff.total_length - {9'b0, offset_in};
      end else begin
         pay_len_in = 16'd0;
      end

      if (done_ff.header_words < 4'd5) begin
         status_in = ipcs_pkg::STATUS_SHORT_HEADER;
      end else if (done_ff.total_length < {9'b0, offset_in}) begin
         status_in = ipcs_pkg::STATUS_SHORT_TOTAL;
      end else begin
         status_in = ipcs_pkg::STATUS_OK;
      end

      ip_ck_in  = ~done_ff.ip_sum;
      tcp_ck_in = ~ipcs_pkg::oc_add(ipcs_pkg::oc_add(done_ff.tcp_sum, ipcs_pkg::ProtoTcp),
                                    tcp_len_in);

      if (done_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (done_move) begin
         ip_ck_ff   <= ip_ck_in;
         tcp_ck_ff  <= tcp_ck_in;
         tcp_len_ff <= tcp_len_in;
         offset_ff  <= offset_in;
         pay_len_ff <= pay_len_in;
         status_ff  <= status_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ip_checksum    = ip_ck_ff;
   assign rsp_tcp_checksum   = tcp_ck_ff;
   assign rsp_tcp_length     = tcp_len_ff;
   assign rsp_payload_offset = offset_ff;
   assign rsp_payload_length = pay_len_ff;
   assign rsp_status         = status_ff;

`ifndef SYNTHESIS
   a_done_held_while_blocked: assert property (@(posedge clock) disable iff (reset)
      (done_valid_ff && !rsp_free) |=> done_valid_ff)
      else $error("closed packet lost while the output was blocked");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (status_ff == ipcs_pkg::STATUS_OK ||
                        status_ff == ipcs_pkg::STATUS_SHORT_HEADER ||
                        status_ff == ipcs_pkg::STATUS_SHORT_TOTAL))
      else $error("result carries an unknown status code");
`endif

endmodule

`default_nettype wire

// ----- src/ipv4_tcp_checksum_engine.sv -----
`default_nettype none

// IPv4/TCP checksum engine. Packet words enter on the req_ channel, one 16-bit
// big-endian word per beat, with req_start_flag on the first word of each packet;
// words seen outside a packet are taken and dropped. The front end tracks the word
// index, header length, total length and TCP data offset and tags each word; a
// short queue hands the tagged words to the back end, which folds each one into
// the IP header sum and the TCP sum with end-around-carry adds. One word is taken
// every cycle while the queue has room, limited by that accumulator stage. The
// word that reaches the total length passes through the queue and the closed-packet
// register before the result beat leaves the output register on the rsp_ channel,
// once the lengths, status and final checksums have been formed in a stage of their
// own. Words past the total length are ignored until the next start flag. An output
// register lets new words keep flowing while a result waits to be taken.
module ipv4_tcp_checksum_engine #(
   parameter int QUEUE_DEPTH = ipcs_pkg::QueueDepth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_packet_word,
   input  wire logic        req_start_flag,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_ip_checksum,
   output logic [15:0]      rsp_tcp_checksum,
   output logic [15:0]      rsp_tcp_length,
   output logic [6:0]       rsp_payload_offset,
   output logic [15:0]      rsp_payload_length,
   output logic [1:0]       rsp_status
);

   logic               q_full;
   logic               q_push;
   ipcs_pkg::item_type q_push_item;
   logic               q_pop;
   logic               q_valid;
   ipcs_pkg::item_type q_pop_item;

   ipcs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_packet_word (req_packet_word),
      .req_start_flag  (req_start_flag),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_item          (q_push_item)
   );

   ipcs_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_item  (q_pop_item)
   );

   ipcs_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_item             (q_pop_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ip_checksum    (rsp_ip_checksum),
      .rsp_tcp_checksum   (rsp_tcp_checksum),
      .rsp_tcp_length     (rsp_tcp_length),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_payload_length (rsp_payload_length),
      .rsp_status         (rsp_status)
   );

endmodule

`default_nettype wire

// ----- tb/checksum_checker.sv -----
// Watches both channels of the checksum engine, predicts every result beat from
// the accepted packet words and compares each result beat against the oldest
// prediction. Hands the failure count and the number of outstanding results to
// the testbench top.
module checksum_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [15:0] req_packet_word,
   input  wire logic        req_start_flag,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [15:0] rsp_ip_checksum,
   input  wire logic [15:0] rsp_tcp_checksum,
   input  wire logic [15:0] rsp_tcp_length,
   input  wire logic [6:0]  rsp_payload_offset,
   input  wire logic [15:0] rsp_payload_length,
   input  wire logic [1:0]  rsp_status,
   output int               fail_count,
   output int               results_pending
);

   localparam int ReportLimit = 10;

   // One result beat as the engine should present it.
   typedef struct packed {
      logic [15:0]          ip_csum;
      logic [15:0]          tcp_csum;
      logic [15:0]          tcp_len;
      logic [6:0]           data_off;
      logic [15:0]          data_len;
      ipcs_pkg::status_type status;
   } sums_type;

   sums_type expected_sums[$];
   int       mismatches = 0;

   // Predicted engine state.
   logic [14:0] word_idx;
   logic [3:0]  ihl_words;
   logic [15:0] tot_len;
   logic [3:0]  tcp_hdr_words;
   logic [15:0] ip_acc;
   logic [15:0] tcp_acc;
   logic        in_packet;

   // End-around-carry addition of two 16-bit words.
   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] wide;
      wide = {1'b0, a} + {1'b0, b};
      return wide[15:0] + {15'd0, wide[16]};
   endfunction

   task automatic clear_packet_state();
      word_idx      = '0;
      ihl_words     = '0;
      tot_len       = '0;
      tcp_hdr_words = '0;
      ip_acc        = '0;
      tcp_acc       = '0;
   endtask

   // Folds one accepted packet word into the sums and queues a result when the
   // word reaches the total length.
   task automatic predict_checksums(input logic [15:0] w, input logic s);
      int unsigned idx, seg, off, tcp_bytes, data_bytes;
      logic [15:0] seg_word, csum;
      sums_type    r;
      if (s) begin
         clear_packet_state();
         in_packet = 1'b1;
      end else if (!in_packet) begin
         // Words outside a packet are dropped.
         return;
      end
      idx = word_idx;
      if (idx == 0) ihl_words = w[11:8];
      if (idx == 1) tot_len = w;

      // IP header sum skips the header checksum word.
      if (idx < 2 * ihl_words && idx != 5) ip_acc = ones_add(ip_acc, w);
      // Source and destination addresses go into the pseudo header.
      if (idx >= 6 && idx <= 9) tcp_acc = ones_add(tcp_acc, w);

      // TCP segment, with bytes at or past the total length zeroed.
      if (idx >= 2 * ihl_words) begin
         seg      = idx - 2 * ihl_words;
         seg_word = w;
         if (idx >= 1) begin
            if (2 * idx >= tot_len) seg_word = '0;
            else if (2 * idx + 1 >= tot_len) seg_word = {w[15:8], 8'h00};
         end
         if (seg == 6) tcp_hdr_words = w[15:12];
         if (seg != 8) tcp_acc = ones_add(tcp_acc, seg_word);
      end
      word_idx = word_idx + 15'd1;

      if (idx < 1 || 2 * (idx + 1) < tot_len) return;

      // Last word of the packet: lengths, status and final checksums.
      off        = 4 * (ihl_words + tcp_hdr_words);
      tcp_bytes  = (tot_len >= 4 * ihl_words) ? tot_len - 4 * ihl_words : 0;
      data_bytes = (tot_len > off) ? tot_len - off : 0;
      csum       = ones_add(ones_add(tcp_acc, ipcs_pkg::ProtoTcp), tcp_bytes[15:0]);
      r.ip_csum  = ~ip_acc;
      r.tcp_csum = ~csum;
      r.tcp_len  = tcp_bytes[15:0];
      r.data_off = off[6:0];
      r.data_len = data_bytes[15:0];
      if (ihl_words < 5) r.status = ipcs_pkg::STATUS_SHORT_HEADER;
      else if (tot_len < off) r.status = ipcs_pkg::STATUS_SHORT_TOTAL;
      else r.status = ipcs_pkg::STATUS_OK;
      expected_sums.push_back(r);
      in_packet = 1'b0;
   endtask

   // Compares one accepted result beat with the oldest prediction.
   task automatic check_result();
      sums_type want, got;
      got = '{rsp_ip_checksum, rsp_tcp_checksum, rsp_tcp_length, rsp_payload_offset,
              rsp_payload_length, ipcs_pkg::status_type'(rsp_status)};
      if (expected_sums.size() == 0) begin
         mismatches++;
         if (mismatches <= ReportLimit)
            $display("unexpected result beat: ip %h tcp %h tcp_len %0d offset %0d len %0d st %0d",
                     got.ip_csum, got.tcp_csum, got.tcp_len, got.data_off, got.data_len,
                     got.status);
         return;
      end
      want = expected_sums.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= ReportLimit) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected: ip %h tcp %h tcp_len %0d offset %0d len %0d st %0d",
                     want.ip_csum, want.tcp_csum, want.tcp_len, want.data_off,
                     want.data_len, want.status);
            $display("  actual:   ip %h tcp %h tcp_len %0d offset %0d len %0d st %0d",
                     got.ip_csum, got.tcp_csum, got.tcp_len, got.data_off, got.data_len,
                     got.status);
         end
      end
   endtask

   // Beats are sampled at the clock edge, before the edge's updates land.
   always @(posedge clock) begin
      if (reset) begin
         clear_packet_state();
         in_packet = 1'b0;
         expected_sums.delete();
      end else begin
         if (req_valid && !req_stall) predict_checksums(req_packet_word, req_start_flag);
         if (rsp_valid && !rsp_stall) check_result();
      end
      results_pending <= expected_sums.size();
      fail_count      <= mismatches;
   end

endmodule

// ----- tb/tb_top.sv -----
// Drives packet words into the checksum engine with random gaps and result
// stalls, and gives the verdict from the checker's failure count.
module tb_top;

   localparam int StallLimit = 2000;
   localparam int RandomWords = 1800;
   localparam int TailWords = 1550;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_packet_word = '0;
   logic        req_start_flag = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_ip_checksum;
   logic [15:0] rsp_tcp_checksum;
   logic [15:0] rsp_tcp_length;
   logic [6:0]  rsp_payload_offset;
   logic [15:0] rsp_payload_length;
   logic [1:0]  rsp_status;
   int          fail_count;
   int          results_pending;

   logic        tail_phase = 1'b0;
   logic        sender_gaps = 1'b0;
   int          words_sent = 0;
   int          quiet_cycles = 0;
   int          stall_hold = 0;
   logic [15:0] frame[$];

   always #5 clock = ~clock;

   ipv4_tcp_checksum_engine u_top (.*);

   checksum_checker u_checker (.*);

   // Result side: random stall bursts between open stretches.
   always @(posedge clock) begin
      if (reset || tail_phase) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else if (rsp_stall) begin
         rsp_stall  <= 1'b0;
         stall_hold <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(0, 12);
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall  <= 1'b1;
         stall_hold <= $urandom_range(0, 8);
      end
   end

   // Watchdog on cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == StallLimit) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // Presents one word beat and waits until it is taken.
   task automatic send_word(input logic [15:0] w, input logic s);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_packet_word <= w;
      req_start_flag  <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // Fills the frame with random words carrying the given header fields.
   task automatic build_frame(input int ihl, input int doff, input int tl, input int nwords);
      int k, doff_at;
      frame.delete();
      for (k = 0; k < nwords; k++) frame.push_back(16'($urandom));
      frame[0] = {4'h4, 4'(ihl), frame[0][7:0]};
      if (nwords > 1) frame[1] = 16'(tl);
      doff_at = 2 * ihl + 6;
      if (doff_at < nwords) frame[doff_at] = {4'(doff), frame[doff_at][11:0]};
   endtask

   // Sends the first count frame words, then trailing words past the packet.
   task automatic send_frame(input int count, input int trailing);
      int k;
      for (k = 0; k < count; k++) send_word(frame[k], k == 0);
      for (k = 0; k < trailing; k++) send_word(16'($urandom), 1'b0);
   endtask

   function automatic int words_for(input int tl);
      return (tl < 4) ? 2 : (tl + 1) / 2;
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
   endtask

   initial begin
      int kind, ihl, doff, tl, n, k;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a word outside any packet is dropped.
      send_word(16'h1234, 1'b0);
      // Zero total length emits on word 1.
      build_frame(5, 5, 0, 2);
      send_frame(2, 0);
      // All-ones first word, total length below 4.
      send_word(16'hFFFF, 1'b1);
      send_word(16'h0003, 1'b0);
      // All-zero words: header length zero.
      send_word(16'h0000, 1'b1);
      send_word(16'h0000, 1'b0);
      // Short header with odd total length, then ignored words past it.
      build_frame(1, 5, 9, 5);
      send_frame(5, 2);
      // Restart in the middle of a packet.
      build_frame(5, 5, 60, 30);
      send_frame(4, 0);
      // Total length below the headers; the data offset word never arrives.
      build_frame(5, 7, 11, 6);
      send_frame(6, 0);

      // Sender holds off until every result is back.
      wait_drained();

      // Largest total length, cut off by the next packet.
      sender_gaps = 1'b1;
      build_frame(5, 15, 65535, 24);
      send_frame(24, 0);

      // Random packets, mostly well formed.
      words_sent = 0;
      while (words_sent < RandomWords) begin
         if (words_sent >= TailWords) begin
            tail_phase  <= 1'b1;
            sender_gaps = 1'b0;
         end else begin
            sender_gaps = ($urandom_range(0, 3) != 0);
         end
         kind = $urandom_range(0, 99);
         ihl  = ($urandom_range(0, 1) == 0) ? 5 : $urandom_range(5, 15);
         doff = $urandom_range(5, 15);
         if (kind < 60) begin
            // Well-formed packet, sometimes followed by stray words.
            tl = 4 * ihl + 4 * doff + $urandom_range(0, 30);
            build_frame(ihl, doff, tl, words_for(tl));
            send_frame(words_for(tl),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
         end else if (kind < 72) begin
            // Any header length and a total length near or below the headers.
            ihl = $urandom_range(0, 15);
            doff = $urandom_range(0, 15);
            tl = $urandom_range(0, 4 * ihl + 4 * doff + 10);
            build_frame(ihl, doff, tl, words_for(tl));
            send_frame(words_for(tl), 0);
         end else if (kind < 84) begin
            // Packet cut short by the next start flag.
            tl = 4 * ihl + 4 * doff + $urandom_range(0, 30);
            n = words_for(tl);
            build_frame(ihl, doff, tl, n);
            send_frame($urandom_range(1, n - 1), 0);
         end else if (kind < 94) begin
            // Noise: random words with an occasional start flag.
            n = $urandom_range(1, 10);
            for (k = 0; k < n; k++)
               send_word(16'($urandom), $urandom_range(0, 7) == 0);
         end else begin
            // Large total length, abandoned early.
            n = $urandom_range(2, 20);
            build_frame($urandom_range(0, 15), $urandom_range(0, 15),
                        $urandom_range(32768, 65535), n);
            send_frame(n, 0);
         end
      end

      // Drain, let the pipeline settle, then report.
      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && results_pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/ipcs_pkg.sv
src/ipcs_front.sv
src/ipcs_queue.sv
src/ipcs_back.sv
src/ipv4_tcp_checksum_engine.sv
tb/checksum_checker.sv
tb/tb_top.sv
